// ===== rtl/core/compact_record_header_encoder_defines.svh =====
// Assertion macros for the compact record header encoder.
// Used by the top level; no other dependencies.
`ifndef COMPACT_RECORD_HEADER_ENCODER_DEFINES_SVH
`define COMPACT_RECORD_HEADER_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CRHE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crhe assertion failed");

// Next-cycle implication, disabled during reset.
`define CRHE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crhe assertion failed");

`endif

// ===== rtl/core/crhe_pkg.sv =====
// Package for the compact record header encoder: field widths, constants,
// transaction and state types. No dependencies.
`default_nettype none

package crhe_pkg;

   localparam int unsigned LEN_W      = 14;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CNT_W      = 2;
   localparam int unsigned OFFSET_W   = 16;
   localparam int unsigned HDR_W      = 12;
   localparam int unsigned NBITS_W    = 3;

   localparam logic [BYTE_W-1:0]   EXTERN_FLAG  = 8'hc0;
   localparam logic [BYTE_W-1:0]   TWO_BYTE_FLAG = 8'h80;
   localparam logic [LEN_W-1:0]    SHORT_LIMIT  = 14'd128;
   localparam logic [OFFSET_W-1:0] DATA_MAX     = 16'hffff;
   localparam logic [HDR_W-1:0]    HEADER_MAX   = 12'hfff;

   localparam logic [CNT_W-1:0] NO_LEN_BYTES  = 2'd0;
   localparam logic [CNT_W-1:0] ONE_LEN_BYTE  = 2'd1;
   localparam logic [CNT_W-1:0] TWO_LEN_BYTES = 2'd2;

   typedef struct packed {
      logic [LEN_W-1:0] field_length;
      logic             nullable;
      logic             is_null;
      logic             fixed_size;
      logic             wide_column;
      logic             external;
      logic             node_pointer;
      logic             last;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0]    length_byte_count;
      logic [BYTE_W-1:0]   length_byte_first;
      logic [BYTE_W-1:0]   length_byte_second;
      logic                null_byte_valid;
      logic [BYTE_W-1:0]   null_byte;
      logic [OFFSET_W-1:0] data_start;
      logic [LEN_W-1:0]    data_count;
      logic [HDR_W-1:0]    header_total;
      logic [OFFSET_W-1:0] data_total;
      logic                record_done;
   } rsp_type;

   // Per-record running state.
   typedef struct packed {
      logic [BYTE_W-1:0]   null_accumulator;
      logic [NBITS_W-1:0]  null_bits_used;
      logic [OFFSET_W-1:0] data_end;
      logic [HDR_W-1:0]    header_count;
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/crhe_channels.sv =====
// Valid/ready channel interfaces for field descriptors and header results.
// Depends on crhe_pkg.
`default_nettype none

interface crhe_req_intf;
   logic                         valid;
   logic                         ready;
   logic [crhe_pkg::LEN_W-1:0]   field_length;
   logic                         nullable;
   logic                         is_null;
   logic                         fixed_size;
   logic                         wide_column;
   logic                         external;
   logic                         node_pointer;
   logic                         last;

   modport source (output valid, field_length, nullable, is_null, fixed_size,
                   wide_column, external, node_pointer, last, input ready);
   modport sink   (input valid, field_length, nullable, is_null, fixed_size,
                   wide_column, external, node_pointer, last, output ready);
endinterface

interface crhe_rsp_intf;
   logic                           valid;
   logic                           ready;
   logic [crhe_pkg::CNT_W-1:0]     length_byte_count;
   logic [crhe_pkg::BYTE_W-1:0]    length_byte_first;
   logic [crhe_pkg::BYTE_W-1:0]    length_byte_second;
   logic                           null_byte_valid;
   logic [crhe_pkg::BYTE_W-1:0]    null_byte;
   logic [crhe_pkg::OFFSET_W-1:0]  data_start;
   logic [crhe_pkg::LEN_W-1:0]     data_count;
   logic [crhe_pkg::HDR_W-1:0]     header_total;
   logic [crhe_pkg::OFFSET_W-1:0]  data_total;
   logic                           record_done;

   modport source (output valid, length_byte_count, length_byte_first,
                   length_byte_second, null_byte_valid, null_byte, data_start,
                   data_count, header_total, data_total, record_done,
                   input ready);
   modport sink   (input valid, length_byte_count, length_byte_first,
                   length_byte_second, null_byte_valid, null_byte, data_start,
                   data_count, header_total, data_total, record_done,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/crhe_field_calc.sv =====
// Combinational per-field encoder: length header bytes, null bitmap,
// data offsets and next record state. Depends on crhe_pkg.
`default_nettype none

module crhe_field_calc (
   input  crhe_pkg::req_type   fld,
   input  crhe_pkg::state_type st,
   output crhe_pkg::rsp_type   res,
   output crhe_pkg::state_type st_next
);

   logic                             done;
   logic                             flag_slot;
   logic                             null_here;
   logic [crhe_pkg::BYTE_W-1:0]      acc_set;
   logic [crhe_pkg::NBITS_W:0]       used_inc;
   logic [crhe_pkg::OFFSET_W:0]      data_sum;
   logic [crhe_pkg::HDR_W:0]         hdr_sum;
   logic [crhe_pkg::BYTE_W-1:0]      len_hi;
   crhe_pkg::state_type              upd;

   always_comb begin
      done      = fld.node_pointer | fld.last;
      flag_slot = ~fld.node_pointer & fld.nullable;
      null_here = flag_slot & fld.is_null;
      len_hi    = {2'b00, fld.field_length[crhe_pkg::LEN_W-1:crhe_pkg::BYTE_W]};

      res = '0;
      res.data_start  = st.data_end;
      res.record_done = done;
      upd = st;

      // null bitmap
      acc_set  = st.null_accumulator |
                 (fld.is_null ? (crhe_pkg::BYTE_W'(1) << st.null_bits_used) : '0);
      used_inc = {1'b0, st.null_bits_used} + 1'b1;
      if (flag_slot) begin
         if (used_inc[crhe_pkg::NBITS_W]) begin
            res.null_byte_valid  = 1'b1;
            res.null_byte        = acc_set;
            upd.null_accumulator = '0;
            upd.null_bits_used   = '0;
         end else begin
            upd.null_accumulator = acc_set;
            upd.null_bits_used   = used_inc[crhe_pkg::NBITS_W-1:0];
         end
      end

      // length header bytes
      if (!fld.node_pointer && !null_here && !fld.fixed_size) begin
         if (fld.external) begin
            res.length_byte_count  = crhe_pkg::TWO_LEN_BYTES;
            res.length_byte_first  = len_hi | crhe_pkg::EXTERN_FLAG;
            res.length_byte_second = fld.field_length[crhe_pkg::BYTE_W-1:0];
         end else if (fld.field_length < crhe_pkg::SHORT_LIMIT || !fld.wide_column) begin
            res.length_byte_count  = crhe_pkg::ONE_LEN_BYTE;
            res.length_byte_first  = fld.field_length[crhe_pkg::BYTE_W-1:0];
         end else begin
            res.length_byte_count  = crhe_pkg::TWO_LEN_BYTES;
            res.length_byte_first  = len_hi | crhe_pkg::TWO_BYTE_FLAG;
            res.length_byte_second = fld.field_length[crhe_pkg::BYTE_W-1:0];
         end
      end

      // running totals, saturating
      data_sum = {1'b0, st.data_end} +
                 (crhe_pkg::OFFSET_W+1)'(fld.field_length);
      if (!null_here) begin
         res.data_count = fld.field_length;
         upd.data_end   = data_sum[crhe_pkg::OFFSET_W] ? crhe_pkg::DATA_MAX :
                          data_sum[crhe_pkg::OFFSET_W-1:0];
      end
      hdr_sum = {1'b0, st.header_count} + (crhe_pkg::HDR_W+1)'(res.length_byte_count);
      upd.header_count = hdr_sum[crhe_pkg::HDR_W] ? crhe_pkg::HEADER_MAX :
                         hdr_sum[crhe_pkg::HDR_W-1:0];

      res.header_total = upd.header_count;
      res.data_total   = upd.data_end;

      // flush a partial bitmap byte at record end
      if (done && !res.null_byte_valid && upd.null_bits_used != '0) begin
         res.null_byte_valid = 1'b1;
         res.null_byte       = upd.null_accumulator;
      end

      st_next = done ? '0 : upd;
   end

endmodule

`default_nettype wire

// ===== rtl/core/compact_record_header_encoder.sv =====
// Top level of the compact record header encoder: input register, field
// encoder and result register. Depends on crhe_pkg, crhe_channels,
// crhe_field_calc and the assertion macro header.
`default_nettype none
`include "compact_record_header_encoder_defines.svh"

// Compact record header encoder. Field descriptors of one record arrive in
// order on req_ch, one per transaction; each yields exactly one result
// transaction on rsp_ch with the field's length header bytes (0, 1 or 2),
// any completed null bitmap byte, the field's data offset and byte count,
// and the running header/data totals (saturating at 4095 / 65535). A field
// with last or node_pointer set closes the record: a partial bitmap byte is
// flushed with its result and the running state returns to zero for the
// next record. Throughput is one field per cycle while rsp_ch does not stall.
// An accepted field passes through the input register, then the result
// register, with the record state updated as the field moves between the
// two. Stalls on rsp_ch back up through both registers; req_ch.ready is
// high when the input register is empty or its field leaves in the same
// cycle, which needs the result register to be free or draining.
module compact_record_header_encoder (
   input  wire logic          clock,
   input  wire logic          reset,
   crhe_req_intf.sink         req_ch,
   crhe_rsp_intf.source       rsp_ch
);

   // input register stage
   logic                 in_valid_ff, in_valid_in;
   crhe_pkg::req_type    in_data_ff, in_data_in;
   // result register stage
   logic                 out_valid_ff, out_valid_in;
   crhe_pkg::rsp_type    out_data_ff, out_data_in;
   // per-record state
   crhe_pkg::state_type  state_ff, state_in;

   crhe_pkg::rsp_type    calc_res;
   crhe_pkg::state_type  calc_state;
   logic                 out_free;
   logic                 advance;
   logic                 req_take;

   crhe_field_calc u_calc (
      .fld     (in_data_ff),
      .st      (state_ff),
      .res     (calc_res),
      .st_next (calc_state)
   );

   always_comb begin
      out_free = ~out_valid_ff | rsp_ch.ready;
      advance  = in_valid_ff & out_free;           // field leaves input register
      req_ch.ready = ~in_valid_ff | advance;
      req_take = req_ch.valid & req_ch.ready;

      in_valid_in = req_take | (in_valid_ff & ~advance);
      in_data_in  = in_data_ff;
      if (req_take) begin
         in_data_in.field_length = req_ch.field_length;
         in_data_in.nullable     = req_ch.nullable;
         in_data_in.is_null      = req_ch.is_null;
         in_data_in.fixed_size   = req_ch.fixed_size;
         in_data_in.wide_column  = req_ch.wide_column;
         in_data_in.external     = req_ch.external;
         in_data_in.node_pointer = req_ch.node_pointer;
         in_data_in.last         = req_ch.last;
      end

      out_valid_in = advance | (out_valid_ff & ~rsp_ch.ready);
      out_data_in  = advance ? calc_res : out_data_ff;
      state_in     = advance ? calc_state : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_ch.valid              = out_valid_ff;
   assign rsp_ch.length_byte_count  = out_data_ff.length_byte_count;
   assign rsp_ch.length_byte_first  = out_data_ff.length_byte_first;
   assign rsp_ch.length_byte_second = out_data_ff.length_byte_second;
   assign rsp_ch.null_byte_valid    = out_data_ff.null_byte_valid;
   assign rsp_ch.null_byte          = out_data_ff.null_byte;
   assign rsp_ch.data_start         = out_data_ff.data_start;
   assign rsp_ch.data_count         = out_data_ff.data_count;
   assign rsp_ch.header_total       = out_data_ff.header_total;
   assign rsp_ch.data_total         = out_data_ff.data_total;
   assign rsp_ch.record_done        = out_data_ff.record_done;

   // record end clears the running state
   `CRHE_ASSERT_NEXT(a_state_cleared_after_done, clock, reset,
      advance && (in_data_ff.last || in_data_ff.node_pointer), state_ff == '0)
   // never three length bytes
   `CRHE_ASSERT_NOW(a_len_count_legal, clock, reset,
      out_valid_ff, out_data_ff.length_byte_count != 2'd3)
   // bitmap byte only shown when flagged
   `CRHE_ASSERT_NOW(a_null_byte_quiet, clock, reset,
      out_valid_ff && !out_data_ff.null_byte_valid, out_data_ff.null_byte == '0)
   // state must hold whenever no field leaves the input register, as in a stall
   `CRHE_ASSERT_NEXT(a_state_holds_on_stall, clock, reset,
      !advance, state_ff == $past(state_ff))

endmodule

`default_nettype wire
